// File: rtl/smx_pkg.sv
// Shared types and constants for the softmax normalizer.
// Holds the transaction payload structs and the elaboration-time exp table helper.
// Depends on nothing.
package smx_pkg;

	localparam int LOGIT_W = 16;
	localparam int PROB_W = 17;
	localparam int SUM_W = 20;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [63:0] LN2_Q32 = 64'd2977044472;
	localparam logic [SUM_W-1:0] SUM_CAP = {SUM_W{1'b1}};

	typedef struct packed {
		logic signed [LOGIT_W-1:0] logit;
		logic is_last;
	} item_t;

	typedef struct packed {
		logic [PROB_W-1:0] probability;
		logic last_out;
		logic truncated;
	} result_t;

	// Evaluates e^(-z) in Q1.16 for z in Q0.32 by a Taylor series.
	function automatic logic [PROB_W-1:0] neg_exp_q16(input logic [63:0] z);
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] r;
		logic [63:0] rnd;
		term = 64'd1 << 32;
		pos = term;
		term = ((term * z) >> 32) / 64'd1;
		neg = term;
		term = ((term * z) >> 32) / 64'd2;
		pos = pos + term;
		term = ((term * z) >> 32) / 64'd3;
		neg = neg + term;
		term = ((term * z) >> 32) / 64'd4;
		pos = pos + term;
		term = ((term * z) >> 32) / 64'd5;
		neg = neg + term;
		term = ((term * z) >> 32) / 64'd6;
		pos = pos + term;
		term = ((term * z) >> 32) / 64'd7;
		neg = neg + term;
		term = ((term * z) >> 32) / 64'd8;
		pos = pos + term;
		term = ((term * z) >> 32) / 64'd9;
		neg = neg + term;
		term = ((term * z) >> 32) / 64'd10;
		pos = pos + term;
		term = ((term * z) >> 32) / 64'd11;
		neg = neg + term;
		term = ((term * z) >> 32) / 64'd12;
		pos = pos + term;
		term = ((term * z) >> 32) / 64'd13;
		neg = neg + term;
		r = (pos > neg) ? (pos - neg) : 64'd0;
		rnd = (r + 64'd32768) >> 16;
		return rnd[PROB_W-1:0];
	endfunction

endpackage

// File: rtl/softmax_normalizer_top.sv
// Top level of the softmax normalizer with its sequencer and shared datapath.
// Depends on smx_pkg and smx_ram.
//
// Usage: a transaction on the input is accepted at a rising edge where start
// is high and busy is low; item carries one signed Q8.8 logit and is_last.
// Logits load at one per cycle while the running maximum is tracked; logits
// beyond MAX_CLASSES are dropped and mark the vector as truncated.
// An item with is_last raises busy. The block then walks the stored logits,
// in five steps each (store read, log2e multiply, table index, table read,
// shift and accumulate), to build exp values and their saturating sum.
// It then divides each exp by the sum with a restoring divider that yields
// one quotient bit per cycle, between a store read with operand load and an
// output step. Each result is presented on result for one cycle with
// result_valid high; last_out marks the final one. The receiver cannot
// stall, so results leave on schedule.
// Reset clears the sequencer, count, maximum, sum and truncation flag; the
// stores are not cleared because every entry is written before it is read.
module softmax_normalizer_top #(
	parameter int MAX_CLASSES = 8,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  smx_pkg::item_t item,
	output logic result_valid,
	output smx_pkg::result_t result
);

	localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int CW = $clog2(MAX_CLASSES + 1);
	localparam int TW = $clog2(EXP_TABLE_DEPTH);
	localparam int TPW = 16 + $clog2(EXP_TABLE_DEPTH + 1);
	localparam int LW = smx_pkg::LOGIT_W;
	localparam int PW = smx_pkg::PROB_W;
	localparam int SW = smx_pkg::SUM_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ERD  = 4'd1;
	localparam logic [3:0] S_EMUL = 4'd2;
	localparam logic [3:0] S_EIDX = 4'd3;
	localparam logic [3:0] S_ETAB = 4'd4;
	localparam logic [3:0] S_EWR  = 4'd5;
	localparam logic [3:0] S_DRD  = 4'd6;
	localparam logic [3:0] S_DLD  = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [PW-1:0] pow2_table [EXP_TABLE_DEPTH];

	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_table
		localparam logic [63:0] ZVAL = (64'(g) * smx_pkg::LN2_Q32) / EXP_TABLE_DEPTH;
		assign pow2_table[g] = smx_pkg::neg_exp_q16(ZVAL);
	end

	logic [3:0] state_q;
	logic [CW-1:0] count_q;
	logic signed [LW-1:0] max_q;
	logic [SW-1:0] sum_q;
	logic trunc_q;
	logic [AW-1:0] idx_q;
	logic [32:0] prod_q;
	logic [TW-1:0] tidx_q;
	logic [4:0] kshift_q;
	logic kill_q;
	logic [PW-1:0] tab_q;
	logic [SW-1:0] rem_q;
	logic [PW-1:0] quo_q;
	logic [4:0] div_cnt_q;
	logic out_valid_q;
	smx_pkg::result_t out_q;

	logic accept;
	logic logit_we;
	logic [LW-1:0] logit_rdata;
	logic exp_we;
	logic [PW-1:0] exp_wdata;
	logic [PW-1:0] exp_rdata;
	logic [LW:0] diff;
	logic [TPW-1:0] tprod;
	logic [8:0] kfull;
	logic [SW:0] sum_add;
	logic [SW:0] trial;
	logic [SW:0] trial_sub;
	logic is_final;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign logit_we = accept && (count_q < CW'(MAX_CLASSES));

	smx_ram #(.WIDTH(LW), .DEPTH(MAX_CLASSES)) u_logit_ram (
		.clk(clk),
		.we(logit_we),
		.waddr(count_q[AW-1:0]),
		.wdata(item.logit),
		.raddr(idx_q),
		.rdata(logit_rdata)
	);

	assign exp_we = (state_q == S_EWR);
	assign exp_wdata = kill_q ? '0 : (tab_q >> kshift_q);

	smx_ram #(.WIDTH(PW), .DEPTH(MAX_CLASSES)) u_exp_ram (
		.clk(clk),
		.we(exp_we),
		.waddr(idx_q),
		.wdata(exp_wdata),
		.raddr(idx_q),
		.rdata(exp_rdata)
	);

	assign diff = {max_q[LW-1], max_q} - {logit_rdata[LW-1], logit_rdata};
	assign tprod = TPW'(prod_q[23:8]) * TPW'(EXP_TABLE_DEPTH);
	assign kfull = prod_q[32:24];
	assign sum_add = {1'b0, sum_q} + (SW+1)'(exp_wdata);
	assign trial = {rem_q, quo_q[PW-1]};
	assign trial_sub = trial - {1'b0, sum_q};
	assign is_final = (CW'(idx_q) == (count_q - CW'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			max_q <= {1'b1, {(LW-1){1'b0}}};
			sum_q <= '0;
			trunc_q <= 1'b0;
			idx_q <= '0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (logit_we) begin
							count_q <= count_q + CW'(1);
							if (count_q == '0 || item.logit > max_q) begin
								max_q <= item.logit;
							end
						end else begin
							trunc_q <= 1'b1;
						end
						if (item.is_last) begin
							idx_q <= '0;
							state_q <= S_ERD;
						end
					end
				end
				S_ERD: state_q <= S_EMUL;
				S_EMUL: state_q <= S_EIDX;
				S_EIDX: state_q <= S_ETAB;
				S_ETAB: state_q <= S_EWR;
				S_EWR: begin
					sum_q <= sum_add[SW] ? smx_pkg::SUM_CAP : sum_add[SW-1:0];
					if (is_final) begin
						idx_q <= '0;
						state_q <= S_DRD;
					end else begin
						idx_q <= idx_q + AW'(1);
						state_q <= S_ERD;
					end
				end
				S_DRD: state_q <= S_DLD;
				S_DLD: begin
					div_cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(PW - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					if (is_final) begin
						count_q <= '0;
						max_q <= {1'b1, {(LW-1){1'b0}}};
						sum_q <= '0;
						trunc_q <= 1'b0;
						idx_q <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
						state_q <= S_DRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_EMUL: prod_q <= 33'(diff[LW-1:0]) * 33'(smx_pkg::LOG2E_Q16);
			S_EIDX: begin
				tidx_q <= tprod[16 +: TW];
				kshift_q <= kfull[4:0];
				kill_q <= (kfull >= 9'd17);
			end
			S_ETAB: tab_q <= pow2_table[tidx_q];
			S_DLD: begin
				rem_q <= SW'(exp_rdata >> 1);
				quo_q <= {exp_rdata[0], {(PW-1){1'b0}}};
			end
			S_DIV: begin
				if (!trial_sub[SW]) begin
					rem_q <= trial_sub[SW-1:0];
					quo_q <= {quo_q[PW-2:0], 1'b1};
				end else begin
					rem_q <= trial[SW-1:0];
					quo_q <= {quo_q[PW-2:0], 1'b0};
				end
			end
			S_OUT: begin
				out_q.probability <= quo_q;
				out_q.last_out <= is_final;
				out_q.truncated <= trunc_q;
			end
			default: begin
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

// File: rtl/smx_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the logit and exp stores of the softmax normalizer.
// Depends on nothing.
module smx_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
